// ----- hw/rtl/netpbm_stream_decoder_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef NETPBM_STREAM_DECODER_UNIT_DEFINES_SVH
`define NETPBM_STREAM_DECODER_UNIT_DEFINES_SVH

// Check that a holds implies b in the same cycle.
`define NSD_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("nsd: implication check failed");

// Check that a holds implies b in the next cycle.
`define NSD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("nsd: next-cycle check failed");

`endif

// ----- hw/rtl/nsd_pkg.sv -----
`default_nettype none

package nsd_pkg;

	localparam logic [1:0] KIND_HEADER   = 2'd0;
	localparam logic [1:0] KIND_SAMPLE   = 2'd1;
	localparam logic [1:0] KIND_BAD_MAG  = 2'd2;
	localparam logic [1:0] KIND_ZERO_MAX = 2'd3;

	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_1  = 8'h31;
	localparam logic [7:0] CH_6  = 8'h36;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [2:0] FMT_PBM_ASCII = 3'd1;
	localparam logic [2:0] FMT_PPM_ASCII = 3'd3;
	localparam logic [2:0] FMT_PBM_BIN   = 3'd4;
	localparam logic [2:0] FMT_PPM_BIN   = 3'd6;

	localparam int QUO_BITS = 8;
	localparam int CNT_BITS = $clog2(QUO_BITS);

	typedef struct packed {
		logic [7:0] file_byte;
		logic       new_file;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sample;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] max_value;
		logic [1:0]  channels;
	} result_t;

	typedef struct packed {
		logic       cap_byte;
		logic       clr_all;
		logic       set_fmt;
		logic       clr_acc;
		logic       add_digit;
		logic       save_w;
		logic       save_h;
		logic       save_max;
		logic       set_max_one;
		logic       load_div;
		logic       div_src_acc;
		logic       div_step;
		logic       out_load;
		logic [1:0] out_kind;
	} cmd_t;

	typedef struct packed {
		logic new_file;
		logic is_p;
		logic type_ok;
		logic digit;
		logic sp;
		logic lf;
		logic fmt_bitmap;
		logic fmt_binary;
		logic acc_zero;
	} sts_t;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		logic [15:0] r;
		r = (|v[31:16]) ? 16'hFFFF : v[15:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nsd_dpath.sv -----
`default_nettype none

module nsd_dpath #(
	parameter int NUMBER_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire nsd_pkg::item_t  item,
	input  wire nsd_pkg::cmd_t   cmd,
	output nsd_pkg::sts_t        sts,
	output nsd_pkg::result_t     result
);

	localparam int NB = NUMBER_BITS;

	logic [7:0]    byte_q;
	logic          new_q;
	logic [2:0]    format_q;
	logic [NB-1:0] acc_q;
	logic [NB-1:0] width_q;
	logic [NB-1:0] height_q;
	logic [NB-1:0] maxv_q;
	logic [NB-1:0] rem_q;
	logic [7:0]    lo_q;
	logic [nsd_pkg::QUO_BITS-1:0] quo_q;
	logic          sat_q;
	nsd_pkg::result_t res_q;

	logic [NB+3:0] acc_x10;
	logic [NB-1:0] acc_dig;
	logic [NB-1:0] div_v;
	logic [NB+7:0] prod;
	logic [NB-1:0] prod_hi;
	logic [NB:0]   trial;
	logic [NB:0]   diff;
	logic          ge;
	nsd_pkg::result_t res_d;

	assign acc_x10 = (NB+4)'({acc_q, 3'b000}) + (NB+4)'({acc_q, 1'b0}) + (NB+4)'(byte_q[3:0]);
	assign acc_dig = (|acc_x10[NB+3:NB]) ? {NB{1'b1}} : acc_x10[NB-1:0];

	assign div_v   = cmd.div_src_acc ? acc_q : NB'(byte_q);
	assign prod    = {div_v, 8'h00} - (NB+8)'(div_v);
	assign prod_hi = prod[NB+7:8];

	assign trial = {rem_q, lo_q[7]};
	assign diff  = trial - {1'b0, maxv_q};
	assign ge    = trial >= {1'b0, maxv_q};

	always_comb begin
		sts.new_file   = new_q;
		sts.is_p       = byte_q == nsd_pkg::CH_P;
		sts.type_ok    = byte_q inside {[nsd_pkg::CH_1:nsd_pkg::CH_6]};
		sts.digit      = byte_q inside {[nsd_pkg::CH_0:nsd_pkg::CH_9]};
		sts.sp         = byte_q == nsd_pkg::CH_SP;
		sts.lf         = byte_q == nsd_pkg::CH_LF;
		sts.fmt_bitmap = format_q inside {nsd_pkg::FMT_PBM_ASCII, nsd_pkg::FMT_PBM_BIN};
		sts.fmt_binary = format_q >= nsd_pkg::FMT_PBM_BIN;
		sts.acc_zero   = acc_q == '0;
	end

	always_comb begin
		res_d.kind         = cmd.out_kind;
		res_d.sample       = '0;
		res_d.image_width  = nsd_pkg::sat16(32'(width_q));
		res_d.image_height = nsd_pkg::sat16(32'(height_q));
		res_d.max_value    = nsd_pkg::sat16(32'(maxv_q));
		res_d.channels     = (format_q inside {nsd_pkg::FMT_PPM_ASCII, nsd_pkg::FMT_PPM_BIN})
			? 2'd3 : 2'd1;
		if (cmd.out_kind == nsd_pkg::KIND_BAD_MAG) begin
			res_d.image_width  = '0;
			res_d.image_height = '0;
			res_d.max_value    = '0;
			res_d.channels     = 2'd1;
		end
		if (cmd.out_kind == nsd_pkg::KIND_SAMPLE) begin
			res_d.sample = sat_q ? 8'hFF : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= '0;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			maxv_q   <= NB'(1);
		end else if (cmd.clr_all) begin
			format_q <= '0;
			acc_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			maxv_q   <= NB'(1);
		end else begin
			if (cmd.set_fmt) begin
				format_q <= byte_q[2:0];
			end
			if (cmd.save_w) begin
				width_q <= acc_q;
			end
			if (cmd.save_h) begin
				height_q <= acc_q;
			end
			if (cmd.save_max) begin
				maxv_q <= acc_q;
			end else if (cmd.set_max_one) begin
				maxv_q <= NB'(1);
			end
			if (cmd.clr_acc) begin
				acc_q <= '0;
			end else if (cmd.add_digit) begin
				acc_q <= acc_dig;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_byte) begin
			byte_q <= item.file_byte;
			new_q  <= item.new_file;
		end
		if (cmd.load_div) begin
			sat_q <= prod_hi >= maxv_q;
			rem_q <= prod_hi;
			lo_q  <= prod[7:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[NB-1:0] : trial[NB-1:0];
			lo_q  <= {lo_q[6:0], 1'b0};
			quo_q <= {quo_q[nsd_pkg::QUO_BITS-2:0], ge};
		end
		if (cmd.out_load) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/nsd_ctrl.sv -----
`default_nettype none

module nsd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  wire logic          result_stall,
	input  wire nsd_pkg::sts_t sts,
	output nsd_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_MAGIC_P,
		PH_MAGIC_T,
		PH_SKIP,
		PH_DIMS,
		PH_MAXV,
		PH_DATA,
		PH_HALT
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d, phase_eff;
	logic [nsd_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
	logic [1:0] kind_q, kind_d;
	logic out_vld_q, out_vld_d;
	logic out_free;

	assign out_free  = !out_vld_q || !result_stall;
	assign phase_eff = sts.new_file ? PH_MAGIC_P : phase_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		kind_d    = kind_q;
		out_vld_d = out_vld_q && result_stall;
		cmd.out_kind = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.cap_byte = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.clr_all = sts.new_file;
				state_d     = ST_IDLE;
				case (phase_eff)
					PH_MAGIC_P: begin
						if (!sts.is_p) begin
							kind_d  = nsd_pkg::KIND_BAD_MAG;
							phase_d = PH_HALT;
							state_d = ST_EMIT;
						end else begin
							phase_d = PH_MAGIC_T;
						end
					end
					PH_MAGIC_T: begin
						if (!sts.type_ok) begin
							kind_d  = nsd_pkg::KIND_BAD_MAG;
							phase_d = PH_HALT;
							state_d = ST_EMIT;
						end else begin
							cmd.set_fmt = 1'b1;
							phase_d     = PH_SKIP;
						end
					end
					PH_SKIP: begin
						cmd.clr_acc = 1'b1;
						phase_d     = PH_DIMS;
					end
					PH_DIMS: begin
						if (sts.sp) begin
							cmd.save_w  = 1'b1;
							cmd.clr_acc = 1'b1;
						end else if (sts.digit) begin
							cmd.add_digit = 1'b1;
						end else if (sts.lf) begin
							cmd.save_h  = 1'b1;
							cmd.clr_acc = 1'b1;
							if (sts.fmt_bitmap) begin
								cmd.set_max_one = 1'b1;
								kind_d          = nsd_pkg::KIND_HEADER;
								phase_d         = PH_DATA;
								state_d         = ST_EMIT;
							end else begin
								phase_d = PH_MAXV;
							end
						end
					end
					PH_MAXV: begin
						if (sts.digit) begin
							cmd.add_digit = 1'b1;
						end else if (sts.lf) begin
							cmd.save_max = 1'b1;
							cmd.clr_acc  = 1'b1;
							state_d      = ST_EMIT;
							if (sts.acc_zero) begin
								kind_d  = nsd_pkg::KIND_ZERO_MAX;
								phase_d = PH_HALT;
							end else begin
								kind_d  = nsd_pkg::KIND_HEADER;
								phase_d = PH_DATA;
							end
						end
					end
					PH_DATA: begin
						if (sts.fmt_binary) begin
							cmd.load_div = 1'b1;
							cnt_d        = '0;
							state_d      = ST_DIV;
						end else if (sts.digit) begin
							cmd.add_digit = 1'b1;
						end else if (sts.sp) begin
							cmd.load_div    = 1'b1;
							cmd.div_src_acc = 1'b1;
							cmd.clr_acc     = 1'b1;
							cnt_d           = '0;
							state_d         = ST_DIV;
						end
					end
					default: begin
						phase_d = PH_HALT;
					end
				endcase
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == nsd_pkg::CNT_BITS'(nsd_pkg::QUO_BITS - 1)) begin
					kind_d  = nsd_pkg::KIND_SAMPLE;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_vld_d    = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_MAGIC_P;
			cnt_q     <= '0;
			kind_q    <= nsd_pkg::KIND_HEADER;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			kind_q    <= kind_d;
			out_vld_q <= out_vld_d;
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = out_vld_q;

endmodule

`default_nettype wire

// ----- hw/rtl/netpbm_stream_decoder_unit.sv -----
// Netpbm stream decoder: parses a PNM file fed one byte per transaction.
// Input channel item (item_valid/item_stall): file_byte plus new_file, which
// marks byte 0 of a file and restarts the parser.
// Output channel result (result_valid/result_stall): at most one result per
// byte; kind tells header done, scaled sample, bad magic or zero maxval.
// A byte without a result is captured in ST_IDLE, then parsed in ST_EXEC.
// A header or error result is loaded in ST_EMIT once the output register is
// free, and the next item is taken after the return to ST_IDLE.
// A sample byte is parsed and multiplied by 255, divided by maxval in the
// restoring divider (ST_DIV), then loaded into the output register in ST_EMIT.
// One item is in work at a time; item_stall is high from acceptance until
// its result is loaded or the byte is consumed without a result.
// The result register holds its transaction while result_stall is high;
// the next item is accepted meanwhile and waits for the register to free.
// Reset clears the parser to expect the 'P' magic byte, with width, height
// and format zero and maxval one, and drops any pending result.
// NUMBER_BITS sets the width of the parsed numbers; they saturate.
`default_nettype none

module netpbm_stream_decoder_unit #(
	parameter int NUMBER_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire nsd_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output nsd_pkg::result_t      result
);

	nsd_pkg::cmd_t cmd;
	nsd_pkg::sts_t sts;

	nsd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	nsd_dpath #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/nsd_checker.sv -----
`default_nettype none

`include "netpbm_stream_decoder_unit_defines.svh"

module nsd_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire nsd_pkg::result_t result
);

	`NSD_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result))
	`NSD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)
	`NSD_ASSERT_IMPLY(a_bad_fields, clk, arst_n,
		result_valid && result.kind == nsd_pkg::KIND_BAD_MAG,
		result.image_width == 16'd0 && result.image_height == 16'd0
		&& result.max_value == 16'd0 && result.channels == 2'd1 && result.sample == 8'd0)
	`NSD_ASSERT_IMPLY(a_sample_max, clk, arst_n,
		result_valid && result.kind == nsd_pkg::KIND_SAMPLE, result.max_value != 16'd0)
	`NSD_ASSERT_IMPLY(a_channels, clk, arst_n, result_valid,
		result.channels == 2'd1 || result.channels == 2'd3)

endmodule

bind netpbm_stream_decoder_unit nsd_checker u_nsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
